>>> src/rfm_pkg.sv
// Rotor force model package: shared constants, codes and memory interface types.
`default_nettype none
package rfm_pkg;

  localparam int MOTORS_DEFAULT = 8;
  localparam int MOTORS_MAX     = 16;
  localparam int ADDR_W         = 4;

  // lag divider sizes
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 21;
  localparam int QUOT_W = 17;
  localparam int REM_W  = 22;

  // arithmetic widths
  localparam int THRUST_W = 41;
  localparam int PROD_W   = 57;
  localparam int FZ_ACC_W = 45;
  localparam int ACC_W    = 51;

  typedef enum logic [1:0] {
    OP_GEOMETRY = 2'd0,
    OP_COMMAND  = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_THRUST_COEF = 3'd0,
    CFG_REACTION    = 3'd1,
    CFG_MAX_VEL     = 3'd2,
    CFG_SPIN_UP     = 3'd3,
    CFG_SPIN_DOWN   = 3'd4,
    CFG_ROTOR_COUNT = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_WR,
    ST_TK_RD,
    ST_TK_LD,
    ST_TK_NUM,
    ST_TK_GO,
    ST_TK_DIV,
    ST_TK_UPD,
    ST_TK_W2,
    ST_TK_KW,
    ST_TK_THR,
    ST_TK_MUL,
    ST_TK_RND,
    ST_TK_ACC,
    ST_TK_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] arm_x;
    logic signed [15:0] arm_y;
    logic               spin_ccw;
  } geo_entry_t;

  typedef struct packed {
    logic [15:0] cmd;
    logic [15:0] cur;
  } spd_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              geo_we;
    logic              spd_we;
    geo_entry_t        geo_wdata;
    spd_entry_t        spd_wdata;
  } mem_req_t;

endpackage
`default_nettype wire

>>> src/multirotor_motor_force_model.sv
// Top level: rotor force model with first-order speed lag and body-frame sums.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   config    | cfg_write             | cfg_index, cfg_data
//   items in  | start & !busy         | opcode, rotor_index, control_level,
//             |                       | tick_dt_us, arm_x_in, arm_y_in, spin_ccw_in
//   result    | done (one cycle)      | force_z, torque_x, torque_y, torque_z
//
// Command items are a read-modify-write of the speed entry. In a tick each
// active rotor is a memory read, the lag divider (skipped for a rotor whose
// chosen time constant is 0), and a chain of registered multiplies (w^2,
// k*w^2, arm and reaction products) before accumulation. rst is synchronous;
// it clears the configuration registers, the accumulators, the state tables
// (via per-entry valid bits) and the control FSM. Results cannot be held off
// by the receiver.
`default_nettype none
module multirotor_motor_force_model #(
  parameter int MOTORS = rfm_pkg::MOTORS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // item transfer
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [2:0]         rotor_index,
  input  wire logic signed [18:0] control_level,
  input  wire logic [15:0]        tick_dt_us,
  input  wire logic signed [15:0] arm_x_in,
  input  wire logic signed [15:0] arm_y_in,
  input  wire logic               spin_ccw_in,
  // result transfer
  output logic                    done,
  output logic [34:0]             force_z,
  output logic signed [39:0]      torque_x,
  output logic signed [39:0]      torque_y,
  output logic signed [39:0]      torque_z
);
  import rfm_pkg::*;

  localparam logic [FZ_ACC_W-1:0] FZ_HI = FZ_ACC_W'(35'h7_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] TQ_HI = ACC_W'(64'sh7F_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] TQ_LO = ACC_W'(-64'sh80_0000_0000);

  // configuration registers
  logic [31:0] thrust_coef;
  logic [15:0] reaction_ratio;
  logic [15:0] max_velocity;
  logic [19:0] spin_up_time;
  logic [19:0] spin_down_time;
  logic [3:0]  rotor_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_coef    <= '0;
      reaction_ratio <= '0;
      max_velocity   <= '0;
      spin_up_time   <= '0;
      spin_down_time <= '0;
      rotor_count    <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        CFG_THRUST_COEF: thrust_coef    <= cfg_data;
        CFG_REACTION:    reaction_ratio <= cfg_data[15:0];
        CFG_MAX_VEL:     max_velocity   <= cfg_data[15:0];
        CFG_SPIN_UP:     spin_up_time   <= cfg_data[19:0];
        CFG_SPIN_DOWN:   spin_down_time <= cfg_data[19:0];
        CFG_ROTOR_COUNT: rotor_count    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control
  state_t state, state_next;
  logic   accept;
  logic   idx_ok;
  logic [ADDR_W:0] n_eff;
  logic [ADDR_W:0] rotor;
  logic   last_rotor;

  assign accept     = start && !busy;
  assign idx_ok     = ({2'b00, rotor_index} < 5'(MOTORS));
  assign n_eff      = ({1'b0, rotor_count} > 5'(MOTORS)) ? 5'(MOTORS) : {1'b0, rotor_count};
  assign last_rotor = (rotor + 5'd1) == n_eff;

  // memory
  mem_req_t   req;
  geo_entry_t geo_rd;
  spd_entry_t spd_rd;

  rfm_state_mem #(.MOTORS(MOTORS)) u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .geo_rd (geo_rd),
    .spd_rd (spd_rd)
  );

  // divider
  logic                div_go;
  logic                div_fin;
  logic [QUOT_W-1:0]   div_quot;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;

  rfm_lag_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num_r),
    .den  (den_r),
    .fin  (div_fin),
    .quot (div_quot)
  );

  // latched item
  logic [2:0]  idx_r;
  logic [16:0] level_r;
  logic [15:0] dt_r;
  logic [32:0] cmd_prod;
  logic [15:0] cmd_new;

  // per-rotor datapath
  geo_entry_t        geo_r;
  logic [15:0]       cmd_r, cur_r, diff_r, cur_new;
  logic              up_r;
  logic [19:0]       tau_r;
  logic [31:0]       w2_r;
  logic [63:0]       kw_r;
  logic [THRUST_W-1:0] thrust_r;
  logic [PROD_W-1:0] px_r, py_r, pz_r;
  logic [PROD_W-12-1:0] rx_r, ry_r;
  logic [PROD_W-16-1:0] rz_r;
  logic [16:0]       step;
  logic [64:0]       kw_round;

  logic [FZ_ACC_W-1:0]    fz_acc;
  logic signed [ACC_W-1:0] tx_acc, ty_acc, tz_acc;

  assign cmd_new  = 16'((cmd_prod + 33'd32768) >> 16);
  assign step     = (div_quot > {1'b0, diff_r}) ? {1'b0, diff_r} : div_quot;
  assign kw_round = {1'b0, kw_r} + 65'd8388608;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    busy          = (state != ST_IDLE);
    div_go        = 1'b0;
    req           = '0;
    req.addr      = ADDR_W'(idx_r);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_e'(opcode))
            OP_GEOMETRY: begin
              req.addr      = ADDR_W'(rotor_index);
              req.geo_we    = idx_ok;
              req.geo_wdata = '{arm_x: arm_x_in, arm_y: arm_y_in, spin_ccw: spin_ccw_in};
            end
            OP_COMMAND: if (idx_ok) state_next = ST_CMD_RD;
            OP_TICK:    state_next = (n_eff == '0) ? ST_TK_OUT : ST_TK_RD;
            default: ;
          endcase
        end
      end
      ST_CMD_RD: begin
        req.rd_en  = 1'b1;
        state_next = ST_CMD_WR;
      end
      ST_CMD_WR: begin
        req.spd_we    = 1'b1;
        req.spd_wdata = '{cmd: cmd_new, cur: spd_rd.cur};
        state_next    = ST_IDLE;
      end
      ST_TK_RD: begin
        req.rd_en  = 1'b1;
        req.addr   = rotor[ADDR_W-1:0];
        state_next = ST_TK_LD;
      end
      ST_TK_LD:  state_next = ST_TK_NUM;
      ST_TK_NUM: state_next = (tau_r == '0) ? ST_TK_W2 : ST_TK_GO;
      ST_TK_GO: begin
        div_go     = 1'b1;
        state_next = ST_TK_DIV;
      end
      ST_TK_DIV: if (div_fin) state_next = ST_TK_UPD;
      ST_TK_UPD: state_next = ST_TK_W2;
      ST_TK_W2: begin
        req.addr      = rotor[ADDR_W-1:0];
        req.spd_we    = 1'b1;
        req.spd_wdata = '{cmd: cmd_r, cur: cur_new};
        state_next    = ST_TK_KW;
      end
      ST_TK_KW:  state_next = ST_TK_THR;
      ST_TK_THR: state_next = ST_TK_MUL;
      ST_TK_MUL: state_next = ST_TK_RND;
      ST_TK_RND: state_next = ST_TK_ACC;
      ST_TK_ACC: state_next = last_rotor ? ST_TK_OUT : ST_TK_RD;
      ST_TK_OUT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      idx_r   <= rotor_index;
      dt_r    <= tick_dt_us;
      // clamp Q16 level to 0..1.0
      if (control_level < 0)                 level_r <= '0;
      else if (control_level > 19'sd65536)   level_r <= 17'd65536;
      else                                   level_r <= control_level[16:0];
    end
    if (state == ST_CMD_RD) cmd_prod <= level_r * max_velocity;

    if (state == ST_TK_LD) begin
      geo_r  <= geo_rd;
      cmd_r  <= spd_rd.cmd;
      cur_r  <= spd_rd.cur;
      up_r   <= spd_rd.cmd > spd_rd.cur;
      diff_r <= (spd_rd.cmd > spd_rd.cur) ? (spd_rd.cmd - spd_rd.cur)
                                           : (spd_rd.cur - spd_rd.cmd);
      tau_r  <= (spd_rd.cmd > spd_rd.cur) ? spin_up_time : spin_down_time;
    end
    if (state == ST_TK_NUM) begin
      // zero time constant: jump straight to the command
      cur_new <= cmd_r;
      den_r   <= DEN_W'(tau_r) + DEN_W'(dt_r);
      num_r   <= NUM_W'(diff_r) * NUM_W'(dt_r)
                 + NUM_W'((DEN_W'(tau_r) + DEN_W'(dt_r)) >> 1);
    end
    if (state == ST_TK_UPD)
      cur_new <= up_r ? (cur_r + step[15:0]) : (cur_r - step[15:0]);
    if (state == ST_TK_W2)  w2_r     <= cur_new * cur_new;
    if (state == ST_TK_KW)  kw_r     <= thrust_coef * w2_r;
    if (state == ST_TK_THR) thrust_r <= kw_round[64:24];
    if (state == ST_TK_MUL) begin
      px_r <= PROD_W'(17'(geo_r.arm_y[15] ? -{geo_r.arm_y[15], geo_r.arm_y}
                                          :  {geo_r.arm_y[15], geo_r.arm_y}))
              * PROD_W'(thrust_r);
      py_r <= PROD_W'(17'(geo_r.arm_x[15] ? -{geo_r.arm_x[15], geo_r.arm_x}
                                          :  {geo_r.arm_x[15], geo_r.arm_x}))
              * PROD_W'(thrust_r);
      pz_r <= PROD_W'(reaction_ratio) * PROD_W'(thrust_r);
    end
    if (state == ST_TK_RND) begin
      rx_r <= (PROD_W-12)'((px_r + PROD_W'(2048)) >> 12);
      ry_r <= (PROD_W-12)'((py_r + PROD_W'(2048)) >> 12);
      rz_r <= (PROD_W-16)'((pz_r + PROD_W'(32768)) >> 16);
    end
    if (state == ST_TK_OUT) begin
      force_z  <= (fz_acc > FZ_HI) ? 35'h7_FFFF_FFFF : fz_acc[34:0];
      torque_x <= (tx_acc > TQ_HI) ? TQ_HI[39:0] : (tx_acc < TQ_LO) ? TQ_LO[39:0] : tx_acc[39:0];
      torque_y <= (ty_acc > TQ_HI) ? TQ_HI[39:0] : (ty_acc < TQ_LO) ? TQ_LO[39:0] : ty_acc[39:0];
      torque_z <= (tz_acc > TQ_HI) ? TQ_HI[39:0] : (tz_acc < TQ_LO) ? TQ_LO[39:0] : tz_acc[39:0];
    end
  end

  // accumulators and rotor walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rotor  <= '0;
      fz_acc <= '0;
      tx_acc <= '0;
      ty_acc <= '0;
      tz_acc <= '0;
      done   <= 1'b0;
    end else begin
      done <= (state == ST_TK_OUT);
      if (state == ST_IDLE && accept) begin
        rotor  <= '0;
        fz_acc <= '0;
        tx_acc <= '0;
        ty_acc <= '0;
        tz_acc <= '0;
      end else if (state == ST_TK_ACC) begin
        rotor  <= rotor + 5'd1;
        fz_acc <= fz_acc + FZ_ACC_W'(thrust_r);
        // x torque follows y arm, y torque opposes x arm
        tx_acc <= geo_r.arm_y[15] ? tx_acc - ACC_W'(rx_r) : tx_acc + ACC_W'(rx_r);
        ty_acc <= geo_r.arm_x[15] ? ty_acc + ACC_W'(ry_r) : ty_acc - ACC_W'(ry_r);
        tz_acc <= geo_r.spin_ccw  ? tz_acc + ACC_W'(rz_r) : tz_acc - ACC_W'(rz_r);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/rfm_state_mem.sv
// Rotor state memories: geometry and speed tables, registered read.
`default_nettype none
module rfm_state_mem #(
  parameter int MOTORS = rfm_pkg::MOTORS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rfm_pkg::mem_req_t req,
  output rfm_pkg::geo_entry_t    geo_rd,
  output rfm_pkg::spd_entry_t    spd_rd
);
  import rfm_pkg::*;

  localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  geo_entry_t geo_mem [MOTORS];
  spd_entry_t spd_mem [MOTORS];
  logic [MOTORS-1:0] geo_ok;
  logic [MOTORS-1:0] spd_ok;

  geo_entry_t geo_q;
  spd_entry_t spd_q;
  logic       geo_ok_q;
  logic       spd_ok_q;

  logic [AW-1:0] addr;
  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.geo_we) geo_mem[addr] <= req.geo_wdata;
    if (req.spd_we) spd_mem[addr] <= req.spd_wdata;
    if (req.rd_en) begin
      geo_q <= geo_mem[addr];
      spd_q <= spd_mem[addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      geo_ok   <= '0;
      spd_ok   <= '0;
      geo_ok_q <= 1'b0;
      spd_ok_q <= 1'b0;
    end else begin
      if (req.geo_we) geo_ok[addr] <= 1'b1;
      if (req.spd_we) spd_ok[addr] <= 1'b1;
      if (req.rd_en) begin
        geo_ok_q <= geo_ok[addr];
        spd_ok_q <= spd_ok[addr];
      end
    end
  end

  assign geo_rd = geo_ok_q ? geo_q : '0;
  assign spd_rd = spd_ok_q ? spd_q : '0;

endmodule
`default_nettype wire

>>> src/rfm_lag_div.sv
// Restoring divider for the lag step, one quotient bit per cycle.
`default_nettype none
module rfm_lag_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [rfm_pkg::NUM_W-1:0]    num,
  input  wire logic [rfm_pkg::DEN_W-1:0]    den,
  output logic                              fin,
  output logic [rfm_pkg::QUOT_W-1:0]        quot
);
  import rfm_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] q;
  logic [DEN_W-1:0]  den_q;
  logic [4:0]        cnt;
  logic              run;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign trial = {rem[REM_W-2:0], q[QUOT_W-1]};
  assign fits  = trial >= REM_W'(den_q);

  always_ff @(posedge clk) begin
    if (go) begin
      // num < den * 2^17, so the high part is already below den
      rem   <= REM_W'(num[NUM_W-1:QUOT_W]);
      q     <= num[QUOT_W-1:0];
      den_q <= den;
    end else if (run) begin
      rem <= fits ? (trial - REM_W'(den_q)) : trial;
      q   <= {q[QUOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(QUOT_W);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule
`default_nettype wire
